// ===== src/wtp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weather telegram parser package
// Byte codes, status codes, field layout and small helpers shared by the
// parser and its storage.
// ----------------------------------------------------------------------------
package wtp_pkg;

    localparam int HISTORY_DEPTH_DEF = 16;

    localparam int BYTE_W  = 8;
    localparam int POS_W   = 6;
    localparam int SUM_W   = 14;
    localparam int WIND_W  = 10;
    localparam int FRAME_DEPTH = 40;

    localparam logic [BYTE_W-1:0] START_BYTE = 8'h57;
    localparam logic [BYTE_W-1:0] END_BYTE   = 8'h03;
    localparam logic [BYTE_W-1:0] YES_CHAR   = 8'h4A;
    localparam logic [BYTE_W-1:0] PLUS_CHAR  = 8'h2B;
    localparam logic [BYTE_W-1:0] MINUS_CHAR = 8'h2D;
    localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;
    localparam logic [BYTE_W-1:0] TAB_CHAR   = 8'h09;
    localparam logic [BYTE_W-1:0] CR_CHAR    = 8'h0D;
    localparam logic [BYTE_W-1:0] ZERO_CHAR  = 8'h30;
    localparam logic [BYTE_W-1:0] NINE_CHAR  = 8'h39;

    localparam logic [POS_W-1:0] SUM_SPAN  = 6'd35;
    localparam logic [POS_W-1:0] FRAME_LEN = 6'd40;
    localparam logic [POS_W-1:0] POS_MAX   = 6'd63;

    localparam logic [1:0] STAT_OK  = 2'd0;
    localparam logic [1:0] STAT_LEN = 2'd1;
    localparam logic [1:0] STAT_SUM = 2'd2;

    // Telegram fields in the order they are decoded.
    typedef logic [3:0] field_t;
    localparam field_t FLD_RX = 4'd0;   // checksum
    localparam field_t FLD_TI = 4'd1;   // temperature, whole degrees
    localparam field_t FLD_TF = 4'd2;   // temperature, tenths
    localparam field_t FLD_SS = 4'd3;
    localparam field_t FLD_SW = 4'd4;
    localparam field_t FLD_SE = 4'd5;
    localparam field_t FLD_DK = 4'd6;
    localparam field_t FLD_LX = 4'd7;
    localparam field_t FLD_WI = 4'd8;   // wind, whole units
    localparam field_t FLD_WF = 4'd9;   // wind, tenths
    localparam field_t FLD_RN = 4'd10;

    typedef enum logic [1:0] {
        PH_WS   = 2'd0,
        PH_DIG  = 2'd1,
        PH_STOP = 2'd2
    } phase_t;

    function automatic logic [POS_W-1:0] fld_start(field_t f);
        logic [POS_W-1:0] s;
        unique case (f)
            FLD_RX:  s = 6'd35;
            FLD_TI:  s = 6'd1;
            FLD_TF:  s = 6'd5;
            FLD_SS:  s = 6'd6;
            FLD_SW:  s = 6'd8;
            FLD_SE:  s = 6'd10;
            FLD_DK:  s = 6'd12;
            FLD_LX:  s = 6'd13;
            FLD_WI:  s = 6'd16;
            FLD_WF:  s = 6'd19;
            FLD_RN:  s = 6'd20;
            default: s = 6'd0;
        endcase
        return s;
    endfunction

    // Offset of the last byte of a field.
    function automatic logic [1:0] fld_last(field_t f);
        logic [1:0] l;
        unique case (f)
            FLD_RX:  l = 2'd3;
            FLD_TI:  l = 2'd2;
            FLD_LX:  l = 2'd2;
            FLD_SS:  l = 2'd1;
            FLD_SW:  l = 2'd1;
            FLD_SE:  l = 2'd1;
            FLD_WI:  l = 2'd1;
            default: l = 2'd0;
        endcase
        return l;
    endfunction

    function automatic logic is_space(logic [BYTE_W-1:0] b);
        return (b == SPACE_CHAR) || ((b >= TAB_CHAR) && (b <= CR_CHAR));
    endfunction

    function automatic logic is_digit(logic [BYTE_W-1:0] b);
        return (b >= ZERO_CHAR) && (b <= NINE_CHAR);
    endfunction

    // Clamp a signed value to 0..hi.
    function automatic logic [9:0] clamp_u(logic signed [15:0] v, logic signed [15:0] hi);
        logic [9:0] r;
        if (v < 16'sd0) begin
            r = '0;
        end else if (v > hi) begin
            r = hi[9:0];
        end else begin
            r = v[9:0];
        end
        return r;
    endfunction

endpackage

// ===== src/wtp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wtp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 40,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/weather_telegram_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weather telegram parser
// Collects ASCII bytes of a weather station telegram and, on ETX, reports
// the checked and decoded telegram together with the wind gust maximum.
// ----------------------------------------------------------------------------
// Usage:
// The s_ channel carries one received byte per item (s_rx_byte). A byte
// that is not ETX is stored and summed as it is accepted, and the block is
// ready again in the next cycle. An ETX byte produces exactly one item on
// the m_ channel.
// If the telegram length is wrong, the result is loaded into the output
// register as soon as that is free. Otherwise a small sequencer reads the 22
// payload bytes back from the telegram RAM, one per cycle, through a single
// number decoder, and stops early if the checksum does not match. It then
// writes the wind value into the history RAM and walks that RAM one entry per
// cycle to find the gust maximum. The history walk and the single RAM read
// port set how long a valid telegram takes from ETX to result. s_ready stays
// low while the sequencer runs.
// The result sits in an output register. If the receiver stalls, s_ready
// returns anyway, and new bytes are taken while the result waits. Only the
// next ETX holds in its final state until the output register is free.
// Reset (aresetn low, synchronous) clears the byte position, the running
// sum, the history pointer and all history valid bits, so the ring reads as
// all zero. The telegram RAM is not cleared.
// ----------------------------------------------------------------------------
module weather_telegram_parser #(
    parameter int HISTORY_DEPTH = wtp_pkg::HISTORY_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic signed [10:0] m_temperature_tenths,
    output logic [6:0]         m_sun_south,
    output logic [6:0]         m_sun_west,
    output logic [6:0]         m_sun_east,
    output logic               m_dark_flag,
    output logic [9:0]         m_daylight_lux,
    output logic [9:0]         m_wind_tenths,
    output logic [9:0]         m_gust_tenths,
    output logic               m_rain_flag,
    output logic [13:0]        m_computed_sum,
    output logic [13:0]        m_received_sum
);

    // Width of a history address. The walk counter has one bit more so that
    // it can hold the depth itself.
    localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [HW:0]   HIST_COUNT = (HW + 1)'(HISTORY_DEPTH);
    localparam logic [HW-1:0] HIST_LAST  = HW'(HISTORY_DEPTH - 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PARSE = 5'b00010,
        ST_HIST  = 5'b00100,
        ST_GUST  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    // Control state.
    state_t                   state_reg, state_next;
    logic [5:0]               pos_reg, pos_next;
    logic [13:0]              sum_reg, sum_next;
    logic                     iss_on_reg, iss_on_next;
    logic                     p_valid_reg, p_valid_next;
    logic [HW-1:0]            hptr_reg, hptr_next;
    logic [HISTORY_DEPTH-1:0] hvalid_reg, hvalid_next;
    logic                     g_pend_reg, g_pend_next;
    logic                     m_valid_reg, m_valid_next;

    // Sequencer payload.
    wtp_pkg::field_t          iss_fld_reg, iss_fld_next;
    logic [1:0]               iss_off_reg, iss_off_next;
    wtp_pkg::field_t          p_fld_reg, p_fld_next;
    logic                     p_first_reg, p_first_next;
    logic                     p_last_reg, p_last_next;
    wtp_pkg::phase_t          ph_reg, ph_next;
    logic                     neg_reg, neg_next;
    logic [13:0]              acc_reg, acc_next;
    logic signed [15:0]       tint_reg, tint_next;
    logic signed [15:0]       wint_reg, wint_next;
    logic [HW:0]              gcnt_reg, gcnt_next;
    logic                     g_tag_reg, g_tag_next;

    // Working result.
    logic [1:0]               r_status_reg, r_status_next;
    logic signed [10:0]       r_temp_reg, r_temp_next;
    logic [6:0]               r_ss_reg, r_ss_next;
    logic [6:0]               r_sw_reg, r_sw_next;
    logic [6:0]               r_se_reg, r_se_next;
    logic                     r_dark_reg, r_dark_next;
    logic [9:0]               r_lux_reg, r_lux_next;
    logic [9:0]               r_wind_reg, r_wind_next;
    logic [9:0]               r_gust_reg, r_gust_next;
    logic                     r_rain_reg, r_rain_next;
    logic [13:0]              r_csum_reg, r_csum_next;
    logic [13:0]              r_rsum_reg, r_rsum_next;

    // Output register.
    logic [1:0]               m_status_reg, m_status_next;
    logic signed [10:0]       m_temp_reg, m_temp_next;
    logic [6:0]               m_ss_reg, m_ss_next;
    logic [6:0]               m_sw_reg, m_sw_next;
    logic [6:0]               m_se_reg, m_se_next;
    logic                     m_dark_reg, m_dark_next;
    logic [9:0]               m_lux_reg, m_lux_next;
    logic [9:0]               m_wind_reg, m_wind_next;
    logic [9:0]               m_gust_reg, m_gust_next;
    logic                     m_rain_reg, m_rain_next;
    logic [13:0]              m_csum_reg, m_csum_next;
    logic [13:0]              m_rsum_reg, m_rsum_next;

    // Memory ports.
    logic                     tel_we;
    logic [5:0]               tel_waddr;
    logic [5:0]               tel_raddr;
    logic [7:0]               tel_rdata;
    logic                     hist_we;
    logic [HW-1:0]            hist_raddr;
    logic [9:0]               hist_rdata;

    // Byte intake.
    logic                     accept;
    logic [5:0]               pos_eff;
    logic [13:0]              sum_eff;
    logic [13:0]              sum_add;
    logic [5:0]               pos_inc;

    // Number decoder.
    wtp_pkg::phase_t          ph_cur, ph_new;
    logic                     neg_cur, neg_new;
    logic [13:0]              acc_cur, acc_new;
    logic [16:0]              acc_x10;
    logic signed [15:0]       acc_s;
    logic signed [15:0]       sval;
    logic signed [15:0]       tcalc;
    logic signed [15:0]       wcalc;
    logic [13:0]              rsum_val;
    logic                     rx_ok;
    logic signed [10:0]       temp_sat;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    // A start byte restarts the telegram and itself becomes byte zero.
    assign pos_eff = (s_rx_byte == wtp_pkg::START_BYTE) ? '0 : pos_reg;
    assign sum_eff = (s_rx_byte == wtp_pkg::START_BYTE) ? '0 : sum_reg;
    assign sum_add = sum_eff + {6'd0, s_rx_byte};
    assign pos_inc = (pos_eff < wtp_pkg::POS_MAX) ? pos_eff + 6'd1 : pos_eff;

    assign tel_we    = accept && (pos_eff < wtp_pkg::FRAME_LEN);
    assign tel_waddr = pos_eff;
    assign tel_raddr = wtp_pkg::fld_start(iss_fld_reg) + {4'd0, iss_off_reg};

    assign hist_raddr = gcnt_reg[HW-1:0];

    wtp_ram #(
        .WIDTH (wtp_pkg::BYTE_W),
        .DEPTH (wtp_pkg::FRAME_DEPTH),
        .AW    (wtp_pkg::POS_W)
    ) u_tel_ram (
        .aclk  (aclk),
        .we    (tel_we),
        .waddr (tel_waddr),
        .wdata (s_rx_byte),
        .raddr (tel_raddr),
        .rdata (tel_rdata)
    );

    wtp_ram #(
        .WIDTH (wtp_pkg::WIND_W),
        .DEPTH (HISTORY_DEPTH),
        .AW    (HW)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (hist_we),
        .waddr (hptr_reg),
        .wdata (r_wind_reg),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    // The decoder works on the byte returned by the telegram RAM. The first
    // byte of a field starts from a fresh state: skip white space, take one
    // optional sign, then collect digits until the first non-digit.
    always_comb begin
        ph_cur  = p_first_reg ? wtp_pkg::PH_WS : ph_reg;
        neg_cur = p_first_reg ? 1'b0 : neg_reg;
        acc_cur = p_first_reg ? '0 : acc_reg;
        ph_new  = ph_cur;
        neg_new = neg_cur;
        acc_new = acc_cur;
        acc_x10 = {acc_cur, 3'b000} + {2'b00, acc_cur, 1'b0} + {13'd0, tel_rdata[3:0]};
        unique case (ph_cur)
            wtp_pkg::PH_WS: begin
                if (wtp_pkg::is_space(tel_rdata)) begin
                    ph_new = wtp_pkg::PH_WS;
                end else if (tel_rdata == wtp_pkg::PLUS_CHAR ||
                             tel_rdata == wtp_pkg::MINUS_CHAR) begin
                    neg_new = (tel_rdata == wtp_pkg::MINUS_CHAR);
                    ph_new  = wtp_pkg::PH_DIG;
                end else if (wtp_pkg::is_digit(tel_rdata)) begin
                    acc_new = acc_x10[13:0];
                    ph_new  = wtp_pkg::PH_DIG;
                end else begin
                    ph_new = wtp_pkg::PH_STOP;
                end
            end
            wtp_pkg::PH_DIG: begin
                if (wtp_pkg::is_digit(tel_rdata)) begin
                    acc_new = acc_x10[13:0];
                end else begin
                    ph_new = wtp_pkg::PH_STOP;
                end
            end
            default: begin
                ph_new = wtp_pkg::PH_STOP;
            end
        endcase

        acc_s = $signed({2'b00, acc_new});
        sval  = neg_new ? -acc_s : acc_s;

        // The tenths digit is added with its own sign, so "-12.5" gives -115.
        tcalc = (tint_reg <<< 3) + (tint_reg <<< 1) + sval;
        wcalc = (wint_reg <<< 3) + (wint_reg <<< 1) + sval;

        if (tcalc > 16'sd999) begin
            temp_sat = 11'sd999;
        end else if (tcalc < -16'sd999) begin
            temp_sat = -11'sd999;
        end else begin
            temp_sat = tcalc[10:0];
        end

        // A negative checksum reads as zero but never matches.
        rsum_val = neg_new ? '0 : acc_new;
        rx_ok    = (rsum_val == r_csum_reg) && !(neg_new && (acc_new != '0));
    end

    always_comb begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        iss_on_next   = iss_on_reg;
        p_valid_next  = 1'b0;
        hptr_next     = hptr_reg;
        hvalid_next   = hvalid_reg;
        g_pend_next   = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;

        iss_fld_next  = iss_fld_reg;
        iss_off_next  = iss_off_reg;
        p_fld_next    = iss_fld_reg;
        p_first_next  = (iss_off_reg == 2'd0);
        p_last_next   = (iss_off_reg == wtp_pkg::fld_last(iss_fld_reg));
        ph_next       = ph_reg;
        neg_next      = neg_reg;
        acc_next      = acc_reg;
        tint_next     = tint_reg;
        wint_next     = wint_reg;
        gcnt_next     = gcnt_reg;
        g_tag_next    = g_tag_reg;

        r_status_next = r_status_reg;
        r_temp_next   = r_temp_reg;
        r_ss_next     = r_ss_reg;
        r_sw_next     = r_sw_reg;
        r_se_next     = r_se_reg;
        r_dark_next   = r_dark_reg;
        r_lux_next    = r_lux_reg;
        r_wind_next   = r_wind_reg;
        r_gust_next   = r_gust_reg;
        r_rain_next   = r_rain_reg;
        r_csum_next   = r_csum_reg;
        r_rsum_next   = r_rsum_reg;

        m_status_next = m_status_reg;
        m_temp_next   = m_temp_reg;
        m_ss_next     = m_ss_reg;
        m_sw_next     = m_sw_reg;
        m_se_next     = m_se_reg;
        m_dark_next   = m_dark_reg;
        m_lux_next    = m_lux_reg;
        m_wind_next   = m_wind_reg;
        m_gust_next   = m_gust_reg;
        m_rain_next   = m_rain_reg;
        m_csum_next   = m_csum_reg;
        m_rsum_next   = m_rsum_reg;

        hist_we       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    pos_next = pos_inc;
                    sum_next = (pos_eff < wtp_pkg::SUM_SPAN) ? sum_add : sum_eff;
                    if (s_rx_byte == wtp_pkg::END_BYTE) begin
                        r_status_next = wtp_pkg::STAT_OK;
                        r_temp_next   = '0;
                        r_ss_next     = '0;
                        r_sw_next     = '0;
                        r_se_next     = '0;
                        r_dark_next   = 1'b0;
                        r_lux_next    = '0;
                        r_wind_next   = '0;
                        r_gust_next   = '0;
                        r_rain_next   = 1'b0;
                        r_rsum_next   = '0;
                        r_csum_next   = (pos_eff < wtp_pkg::SUM_SPAN) ? sum_add : sum_eff;
                        if (pos_inc != wtp_pkg::FRAME_LEN) begin
                            r_status_next = wtp_pkg::STAT_LEN;
                            state_next    = ST_DONE;
                        end else begin
                            iss_on_next  = 1'b1;
                            iss_fld_next = wtp_pkg::FLD_RX;
                            iss_off_next = 2'd0;
                            state_next   = ST_PARSE;
                        end
                    end
                end
            end

            ST_PARSE: begin
                // Read side: one telegram byte address per cycle.
                if (iss_on_reg) begin
                    p_valid_next = 1'b1;
                    if (iss_off_reg == wtp_pkg::fld_last(iss_fld_reg)) begin
                        iss_off_next = 2'd0;
                        iss_fld_next = iss_fld_reg + 4'd1;
                        if (iss_fld_reg == wtp_pkg::FLD_RN) begin
                            iss_on_next = 1'b0;
                        end
                    end else begin
                        iss_off_next = iss_off_reg + 2'd1;
                    end
                end
                // Decode side: the byte read in the cycle before.
                if (p_valid_reg) begin
                    ph_next  = ph_new;
                    neg_next = neg_new;
                    acc_next = acc_new;
                    if (p_last_reg) begin
                        unique case (p_fld_reg)
                            wtp_pkg::FLD_RX: begin
                                r_rsum_next = rsum_val;
                                if (!rx_ok) begin
                                    r_status_next = wtp_pkg::STAT_SUM;
                                    iss_on_next   = 1'b0;
                                    p_valid_next  = 1'b0;
                                    state_next    = ST_DONE;
                                end
                            end
                            wtp_pkg::FLD_TI: tint_next = sval;
                            wtp_pkg::FLD_TF: r_temp_next = temp_sat;
                            wtp_pkg::FLD_SS: r_ss_next = 7'(wtp_pkg::clamp_u(sval, 16'sd99));
                            wtp_pkg::FLD_SW: r_sw_next = 7'(wtp_pkg::clamp_u(sval, 16'sd99));
                            wtp_pkg::FLD_SE: r_se_next = 7'(wtp_pkg::clamp_u(sval, 16'sd99));
                            wtp_pkg::FLD_DK: r_dark_next = (tel_rdata == wtp_pkg::YES_CHAR);
                            wtp_pkg::FLD_LX: r_lux_next = wtp_pkg::clamp_u(sval, 16'sd999);
                            wtp_pkg::FLD_WI: wint_next = sval;
                            wtp_pkg::FLD_WF: r_wind_next = wtp_pkg::clamp_u(wcalc, 16'sd999);
                            wtp_pkg::FLD_RN: begin
                                r_rain_next = (tel_rdata == wtp_pkg::YES_CHAR);
                                state_next  = ST_HIST;
                            end
                            default: begin
                                state_next = ST_HIST;
                            end
                        endcase
                    end
                end
            end

            ST_HIST: begin
                hist_we                 = 1'b1;
                hvalid_next[hptr_reg]   = 1'b1;
                hptr_next   = (hptr_reg == HIST_LAST) ? '0 : hptr_reg + HW'(1);
                gcnt_next   = '0;
                r_gust_next = '0;
                state_next  = ST_GUST;
            end

            ST_GUST: begin
                // Entries never written are skipped by their valid bit and cannot raise the maximum.
                if (gcnt_reg < HIST_COUNT) begin
                    g_pend_next = 1'b1;
                    g_tag_next  = hvalid_reg[gcnt_reg[HW-1:0]];
                    gcnt_next   = gcnt_reg + (HW + 1)'(1);
                end
                if (g_pend_reg && g_tag_reg && (hist_rdata > r_gust_reg)) begin
                    r_gust_next = hist_rdata;
                end
                if ((gcnt_reg == HIST_COUNT) && !g_pend_reg) begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = r_status_reg;
                    m_temp_next   = r_temp_reg;
                    m_ss_next     = r_ss_reg;
                    m_sw_next     = r_sw_reg;
                    m_se_next     = r_se_reg;
                    m_dark_next   = r_dark_reg;
                    m_lux_next    = r_lux_reg;
                    m_wind_next   = r_wind_reg;
                    m_gust_next   = r_gust_reg;
                    m_rain_next   = r_rain_reg;
                    m_csum_next   = r_csum_reg;
                    m_rsum_next   = r_rsum_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            sum_reg     <= '0;
            iss_on_reg  <= 1'b0;
            p_valid_reg <= 1'b0;
            hptr_reg    <= '0;
            hvalid_reg  <= '0;
            g_pend_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            sum_reg     <= sum_next;
            iss_on_reg  <= iss_on_next;
            p_valid_reg <= p_valid_next;
            hptr_reg    <= hptr_next;
            hvalid_reg  <= hvalid_next;
            g_pend_reg  <= g_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        iss_fld_reg  <= iss_fld_next;
        iss_off_reg  <= iss_off_next;
        p_fld_reg    <= p_fld_next;
        p_first_reg  <= p_first_next;
        p_last_reg   <= p_last_next;
        ph_reg       <= ph_next;
        neg_reg      <= neg_next;
        acc_reg      <= acc_next;
        tint_reg     <= tint_next;
        wint_reg     <= wint_next;
        gcnt_reg     <= gcnt_next;
        g_tag_reg    <= g_tag_next;

        r_status_reg <= r_status_next;
        r_temp_reg   <= r_temp_next;
        r_ss_reg     <= r_ss_next;
        r_sw_reg     <= r_sw_next;
        r_se_reg     <= r_se_next;
        r_dark_reg   <= r_dark_next;
        r_lux_reg    <= r_lux_next;
        r_wind_reg   <= r_wind_next;
        r_gust_reg   <= r_gust_next;
        r_rain_reg   <= r_rain_next;
        r_csum_reg   <= r_csum_next;
        r_rsum_reg   <= r_rsum_next;

        m_status_reg <= m_status_next;
        m_temp_reg   <= m_temp_next;
        m_ss_reg     <= m_ss_next;
        m_sw_reg     <= m_sw_next;
        m_se_reg     <= m_se_next;
        m_dark_reg   <= m_dark_next;
        m_lux_reg    <= m_lux_next;
        m_wind_reg   <= m_wind_next;
        m_gust_reg   <= m_gust_next;
        m_rain_reg   <= m_rain_next;
        m_csum_reg   <= m_csum_next;
        m_rsum_reg   <= m_rsum_next;
    end

    assign m_valid              = m_valid_reg;
    assign m_status             = m_status_reg;
    assign m_temperature_tenths = m_temp_reg;
    assign m_sun_south          = m_ss_reg;
    assign m_sun_west           = m_sw_reg;
    assign m_sun_east           = m_se_reg;
    assign m_dark_flag          = m_dark_reg;
    assign m_daylight_lux       = m_lux_reg;
    assign m_wind_tenths        = m_wind_reg;
    assign m_gust_tenths        = m_gust_reg;
    assign m_rain_flag          = m_rain_reg;
    assign m_computed_sum       = m_csum_reg;
    assign m_received_sum       = m_rsum_reg;

    // A valid telegram must carry a matching checksum.
    a_ok_sum_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == wtp_pkg::STAT_OK) |-> m_computed_sum == m_received_sum)
        else $error("valid result with mismatching checksum");

    // The gust maximum includes the wind value just written.
    a_gust_covers_wind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == wtp_pkg::STAT_OK) |-> m_gust_tenths >= m_wind_tenths)
        else $error("gust below current wind");

    // Rejected telegrams report no decoded data.
    a_bad_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != wtp_pkg::STAT_OK) |->
            (m_wind_tenths == '0) && (m_gust_tenths == '0) &&
            (m_temperature_tenths == '0) && !m_rain_flag && !m_dark_flag)
        else $error("rejected telegram carries data");

    // Bytes other than ETX never keep the block busy.
    a_plain_byte_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_rx_byte != wtp_pkg::END_BYTE) |=> s_ready)
        else $error("block busy after a plain byte");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == wtp_pkg::STAT_OK) || (m_status == wtp_pkg::STAT_LEN) ||
                    (m_status == wtp_pkg::STAT_SUM))
        else $error("undefined status code");

endmodule

// ===== bench/weather_telegram_parser_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weather telegram parser testbench
// Feeds byte streams into the parser: hand-built telegrams for the corner
// cases first, then mostly well-formed random telegrams mixed with
// fragments, stray ETX bytes and raw noise. A byte-level model of the parser
// predicts every report, and each report from the block is checked field by
// field against it.
// ----------------------------------------------------------------------------
module weather_telegram_parser_test;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 5;
    localparam int IDLE_PCT     = 6;
    localparam int RANDOM_BYTES = 1150;
    localparam int MIN_REPORTS  = 24;
    // The drain wait after the last report is longer than the time a valid
    // telegram needs from ETX to report.
    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic [7:0] DOT_CHAR = 8'h2E;
    localparam logic [7:0] NO_CHAR  = 8'h4E;

    // How the decimal checksum at positions 35 to 38 is written.
    typedef enum int {
        SUM_ZERO_PAD,
        SUM_BLANK_PAD,
        SUM_SIGNED,
        SUM_WRONG,
        SUM_NEGATIVE
    } sum_style_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [10:0] temp;
        logic [6:0]         sun_s;
        logic [6:0]         sun_w;
        logic [6:0]         sun_e;
        logic               dark;
        logic [9:0]         lux;
        logic [9:0]         wind;
        logic [9:0]         gust;
        logic               rain;
        logic [13:0]        csum;
        logic [13:0]        rsum;
    } weather_report_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_rx_byte;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_status;
    logic signed [10:0] m_temperature_tenths;
    logic [6:0]         m_sun_south;
    logic [6:0]         m_sun_west;
    logic [6:0]         m_sun_east;
    logic               m_dark_flag;
    logic [9:0]         m_daylight_lux;
    logic [9:0]         m_wind_tenths;
    logic [9:0]         m_gust_tenths;
    logic               m_rain_flag;
    logic [13:0]        m_computed_sum;
    logic [13:0]        m_received_sum;

    // Stimulus bookkeeping.
    logic [7:0]      byte_backlog [$];
    weather_report_t pending_reports [$];
    logic [7:0]      draft [wtp_pkg::FRAME_DEPTH];
    int              etx_count;
    int              bytes_offered;
    int              bytes_taken;
    int              failures;
    int              cycle_count;

    // Parser model state: position, running sum, stored telegram, wind ring.
    logic [5:0]      frame_pos;
    logic [13:0]     frame_sum;
    logic [7:0]      frame_bytes [wtp_pkg::FRAME_DEPTH];
    logic [9:0]      wind_ring [wtp_pkg::HISTORY_DEPTH_DEF];
    int              ring_slot;

    // Both sides run without any idle cycles while this window of bytes
    // goes through, so back-to-back traffic is covered too.
    wire quiet = (bytes_taken >= 300) && (bytes_taken < 600);

    weather_telegram_parser #(
        .HISTORY_DEPTH(wtp_pkg::HISTORY_DEPTH_DEF)
    ) uut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_rx_byte            (s_rx_byte),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_status             (m_status),
        .m_temperature_tenths (m_temperature_tenths),
        .m_sun_south          (m_sun_south),
        .m_sun_west           (m_sun_west),
        .m_sun_east           (m_sun_east),
        .m_dark_flag          (m_dark_flag),
        .m_daylight_lux       (m_daylight_lux),
        .m_wind_tenths        (m_wind_tenths),
        .m_gust_tenths        (m_gust_tenths),
        .m_rain_flag          (m_rain_flag),
        .m_computed_sum       (m_computed_sum),
        .m_received_sum       (m_received_sum)
    );

    always begin
        aclk = 1'b0;
        #CLK_HALF;
        aclk = 1'b1;
        #CLK_HALF;
    end

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------

    // Reads a stored span the way C atoi does: skip white space, take one
    // optional sign, then digits up to the first non-digit or span end.
    function automatic int span_value(input int first, input int len);
        int  i;
        int  stop;
        int  v;
        logic minus;
        i = first;
        stop = first + len;
        v = 0;
        minus = 1'b0;
        while (i < stop && (frame_bytes[i] == wtp_pkg::SPACE_CHAR ||
               (frame_bytes[i] >= wtp_pkg::TAB_CHAR &&
                frame_bytes[i] <= wtp_pkg::CR_CHAR)))
            i++;
        if (i < stop && (frame_bytes[i] == wtp_pkg::PLUS_CHAR ||
                         frame_bytes[i] == wtp_pkg::MINUS_CHAR)) begin
            minus = (frame_bytes[i] == wtp_pkg::MINUS_CHAR);
            i++;
        end
        while (i < stop && frame_bytes[i] >= wtp_pkg::ZERO_CHAR &&
               frame_bytes[i] <= wtp_pkg::NINE_CHAR) begin
            v = v * 10 + int'(frame_bytes[i]) - int'(wtp_pkg::ZERO_CHAR);
            i++;
        end
        return minus ? -v : v;
    endfunction

    function automatic int pin(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Applies one accepted byte to the model. An ETX byte queues the report
    // that the block has to produce for it.
    task automatic absorb_byte(input logic [7:0] b);
        weather_report_t rep;
        int rx;
        int t;
        int w;
        int peak;
        int k;
        if (b == wtp_pkg::START_BYTE) begin
            frame_pos = '0;
            frame_sum = '0;
        end
        if (frame_pos < wtp_pkg::FRAME_LEN)
            frame_bytes[frame_pos] = b;
        if (frame_pos < wtp_pkg::SUM_SPAN)
            frame_sum = frame_sum + 14'(b);
        // The position counter saturates, so very long streams never wrap
        // back into a valid length.
        if (frame_pos < wtp_pkg::POS_MAX)
            frame_pos = frame_pos + 6'd1;
        if (b == wtp_pkg::END_BYTE) begin
            rep = '0;
            rep.status = wtp_pkg::STAT_LEN;
            rep.csum = frame_sum;
            if (frame_pos == wtp_pkg::FRAME_LEN) begin
                rx = span_value(35, 4);
                // A negative checksum reads as zero and can never match.
                rep.rsum = 14'(pin(rx, 0, 9999));
                rep.status = wtp_pkg::STAT_SUM;
                if (rx == int'(frame_sum)) begin
                    rep.status = wtp_pkg::STAT_OK;
                    // The tenths digit is added even for a negative
                    // temperature.
                    t = pin(span_value(1, 3) * 10 + span_value(5, 1), -999, 999);
                    rep.temp = 11'(t);
                    rep.sun_s = 7'(pin(span_value(6, 2), 0, 99));
                    rep.sun_w = 7'(pin(span_value(8, 2), 0, 99));
                    rep.sun_e = 7'(pin(span_value(10, 2), 0, 99));
                    rep.dark = (frame_bytes[12] == wtp_pkg::YES_CHAR);
                    rep.lux = 10'(pin(span_value(13, 3), 0, 999));
                    w = pin(span_value(16, 2) * 10 + span_value(19, 1), 0, 999);
                    rep.wind = 10'(w);
                    rep.rain = (frame_bytes[20] == wtp_pkg::YES_CHAR);
                    // The clamped wind value enters the ring; the gust is
                    // the largest entry of the whole ring.
                    wind_ring[ring_slot] = 10'(w);
                    ring_slot = (ring_slot + 1) % wtp_pkg::HISTORY_DEPTH_DEF;
                    peak = 0;
                    for (k = 0; k < wtp_pkg::HISTORY_DEPTH_DEF; k++)
                        if (int'(wind_ring[k]) > peak)
                            peak = int'(wind_ring[k]);
                    rep.gust = 10'(peak);
                end
            end
            pending_reports.push_back(rep);
        end
    endtask

    // ------------------------------------------------------------------
    // Report checking
    // ------------------------------------------------------------------

    task automatic match_field(input string label, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", label, want, got);
            failures++;
        end
    endtask

    task automatic check_report();
        weather_report_t want;
        if (pending_reports.size() == 0) begin
            $error("report with status %0d arrived while none was due", m_status);
            failures++;
        end else begin
            want = pending_reports.pop_front();
            match_field("status", want.status, m_status);
            match_field("temperature_tenths", $signed(want.temp),
                        $signed(m_temperature_tenths));
            match_field("sun_south", want.sun_s, m_sun_south);
            match_field("sun_west", want.sun_w, m_sun_west);
            match_field("sun_east", want.sun_e, m_sun_east);
            match_field("dark_flag", want.dark, m_dark_flag);
            match_field("daylight_lux", want.lux, m_daylight_lux);
            match_field("wind_tenths", want.wind, m_wind_tenths);
            match_field("gust_tenths", want.gust, m_gust_tenths);
            match_field("rain_flag", want.rain, m_rain_flag);
            match_field("computed_sum", want.csum, m_computed_sum);
            match_field("received_sum", want.rsum, m_received_sum);
        end
    endtask

    // ------------------------------------------------------------------
    // Telegram building
    // ------------------------------------------------------------------

    task automatic queue_byte(input logic [7:0] b);
        byte_backlog.push_back(b);
        if (b == wtp_pkg::END_BYTE)
            etx_count++;
    endtask

    function automatic logic [7:0] digit_char();
        return 8'(wtp_pkg::ZERO_CHAR + $urandom_range(9));
    endfunction

    function automatic logic [7:0] flag_char();
        return ($urandom_range(1) != 0) ? wtp_pkg::YES_CHAR : NO_CHAR;
    endfunction

    // Mostly digits, with white space, signs and arbitrary bytes thrown in.
    // Start and end bytes are kept out so the telegram stays in one piece.
    function automatic logic [7:0] rough_char();
        logic [7:0] c;
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) begin
            c = digit_char();
        end else if (pick < 68) begin
            c = wtp_pkg::SPACE_CHAR;
        end else if (pick < 74) begin
            c = 8'($urandom_range(wtp_pkg::CR_CHAR, wtp_pkg::TAB_CHAR));
        end else if (pick < 82) begin
            c = (pick < 78) ? wtp_pkg::PLUS_CHAR : wtp_pkg::MINUS_CHAR;
        end else if (pick < 86) begin
            c = wtp_pkg::YES_CHAR;
        end else begin
            do
                c = 8'($urandom_range(255));
            while (c == wtp_pkg::START_BYTE || c == wtp_pkg::END_BYTE);
        end
        return c;
    endfunction

    task automatic put_text(input int at, input string s);
        int k;
        for (k = 0; k < s.len(); k++)
            draft[at + k] = s[k];
    endtask

    // Lays out a telegram the way the station sends it: signed temperature
    // with tenths, three sun values, darkness flag, daylight, wind with
    // tenths, rain flag, then a printable tail that only counts in the sum.
    task automatic fill_clean_draft();
        int k;
        draft[0] = wtp_pkg::START_BYTE;
        case ($urandom_range(3))
            0: draft[1] = wtp_pkg::PLUS_CHAR;
            1: draft[1] = wtp_pkg::MINUS_CHAR;
            2: draft[1] = wtp_pkg::SPACE_CHAR;
            default: draft[1] = digit_char();
        endcase
        draft[2] = digit_char();
        draft[3] = digit_char();
        draft[4] = DOT_CHAR;
        draft[5] = digit_char();
        for (k = 6; k < 12; k++)
            draft[k] = digit_char();
        draft[12] = flag_char();
        for (k = 13; k < 16; k++)
            draft[k] = digit_char();
        // Calm weather half the time, so a strong gust can age out of the
        // ring instead of dominating it forever.
        draft[16] = ($urandom_range(1) != 0) ? wtp_pkg::ZERO_CHAR : digit_char();
        draft[17] = digit_char();
        draft[18] = DOT_CHAR;
        draft[19] = digit_char();
        draft[20] = flag_char();
        for (k = 21; k < wtp_pkg::SUM_SPAN; k++) begin
            do
                draft[k] = 8'($urandom_range(8'h7E, 8'h20));
            while (draft[k] == wtp_pkg::START_BYTE);
        end
    endtask

    task automatic fill_rough_draft();
        int k;
        draft[0] = wtp_pkg::START_BYTE;
        for (k = 1; k < wtp_pkg::SUM_SPAN; k++)
            draft[k] = rough_char();
    endtask

    // Writes the checksum field and ETX, then queues the 40 bytes.
    task automatic seal_draft(input sum_style_t style);
        int total;
        int k;
        string digits;
        total = 0;
        for (k = 0; k < wtp_pkg::SUM_SPAN; k++)
            total += draft[k];
        case (style)
            SUM_BLANK_PAD: digits = $sformatf("%4d", total);
            SUM_SIGNED:    digits = (total < 1000) ? $sformatf("+%03d", total)
                                                   : $sformatf("%04d", total);
            SUM_WRONG:     digits = $sformatf("%04d", total + $urandom_range(40, 1));
            SUM_NEGATIVE:  digits = $sformatf("-%03d", $urandom_range(999));
            default:       digits = $sformatf("%04d", total);
        endcase
        put_text(35, digits);
        draft[wtp_pkg::FRAME_DEPTH - 1] = wtp_pkg::END_BYTE;
        for (k = 0; k < wtp_pkg::FRAME_DEPTH; k++)
            queue_byte(draft[k]);
    endtask

    function automatic sum_style_t pick_sum_style();
        int pick;
        pick = $urandom_range(99);
        if (pick < 80)
            return SUM_ZERO_PAD;
        else if (pick < 85)
            return SUM_BLANK_PAD;
        else if (pick < 88)
            return SUM_SIGNED;
        else if (pick < 96)
            return SUM_WRONG;
        return SUM_NEGATIVE;
    endfunction

    // A start byte, len - 1 more payload bytes, then ETX: a telegram of
    // len + 1 bytes, which is the right length only for len == 39.
    task automatic queue_fragment(input int len);
        int k;
        fill_clean_draft();
        for (k = 0; k < len; k++)
            queue_byte((k < wtp_pkg::SUM_SPAN) ? draft[k] : digit_char());
        queue_byte(wtp_pkg::END_BYTE);
    endtask

    // ------------------------------------------------------------------
    // Input driver and output handshake, both changed on the falling edge
    // ------------------------------------------------------------------

    // A new byte is offered only when nothing is pending or the pending one
    // was taken at the last rising edge, so valid never drops early.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || bytes_taken == bytes_offered) begin
                if (byte_backlog.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
                    s_rx_byte <= byte_backlog.pop_front();
                    s_valid <= 1'b1;
                    bytes_offered++;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Both channels are sampled at the rising edge, where the handshake
    // actually happens.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                absorb_byte(s_rx_byte);
                bytes_taken++;
            end
            if (m_valid && m_ready)
                check_report();
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------

    initial begin
        int k;
        int pick;
        int len;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_rx_byte = '0;
        m_ready = 1'b0;
        etx_count = 0;
        bytes_offered = 0;
        bytes_taken = 0;
        failures = 0;
        cycle_count = 0;
        frame_pos = '0;
        frame_sum = '0;
        ring_slot = 0;
        for (k = 0; k < wtp_pkg::FRAME_DEPTH; k++)
            frame_bytes[k] = '0;
        for (k = 0; k < wtp_pkg::HISTORY_DEPTH_DEF; k++)
            wind_ring[k] = '0;

        // Right after reset, a telegram without its start byte still counts:
        // the position starts at zero, so 40 bytes ending in ETX are valid.
        fill_clean_draft();
        draft[0] = 8'hFF;
        seal_draft(SUM_ZERO_PAD);

        // Every field at its top value; temperature saturates, wind just reaches 999.
        fill_clean_draft();
        put_text(1, "999.9999999J999");
        put_text(16, "99.9J");
        seal_draft(SUM_ZERO_PAD);

        // Negative temperature keeps the added tenths digit.
        fill_clean_draft();
        put_text(1, "-12.5");
        put_text(16, "00.0N");
        seal_draft(SUM_ZERO_PAD);

        // Lowest reachable temperature, tenths read as a lone sign.
        fill_clean_draft();
        put_text(1, "-99.-");
        seal_draft(SUM_SIGNED);

        // White space, signs and negative values that clamp to zero.
        fill_clean_draft();
        put_text(1, "  0.-");
        put_text(6, " 0+5-3j  7-1.5N");
        draft[2] = wtp_pkg::TAB_CHAR;
        draft[14] = wtp_pkg::CR_CHAR;
        seal_draft(SUM_ZERO_PAD);

        // Digits stop at the first non-digit character.
        fill_clean_draft();
        put_text(1, "1x5.7+-9-");
        put_text(13, "4A2");
        seal_draft(SUM_ZERO_PAD);

        // Mostly zero bytes: a small sum written with leading blanks.
        draft[0] = wtp_pkg::START_BYTE;
        for (k = 1; k < wtp_pkg::SUM_SPAN; k++)
            draft[k] = 8'h00;
        seal_draft(SUM_BLANK_PAD);

        // Checksum mismatch, and a negative checksum.
        fill_clean_draft();
        seal_draft(SUM_WRONG);
        fill_clean_draft();
        seal_draft(SUM_NEGATIVE);

        // Nothing is cleared after ETX, so a second ETX makes 41 bytes.
        queue_byte(wtp_pkg::END_BYTE);

        // Too short, one too long, and long enough to saturate the position.
        queue_fragment(5);
        queue_fragment(40);
        queue_fragment(70);

        // Random part: mostly whole telegrams with random content, the rest
        // rough telegrams, broken sequences, noise and stray ETX bytes.
        while (byte_backlog.size() < RANDOM_BYTES || etx_count < MIN_REPORTS) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                fill_clean_draft();
                seal_draft(pick_sum_style());
            end else if (pick < 75) begin
                fill_rough_draft();
                seal_draft(pick_sum_style());
            end else if (pick < 85) begin
                queue_fragment($urandom_range(70, 1));
            end else if (pick < 95) begin
                len = $urandom_range(12, 1);
                for (k = 0; k < len; k++)
                    queue_byte(8'($urandom_range(255)));
            end else begin
                queue_byte(wtp_pkg::END_BYTE);
            end
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        wait (byte_backlog.size() == 0 && bytes_taken == bytes_offered &&
              pending_reports.size() == 0);
        // Give a late spurious report the chance to show up.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
